>>> rtl/core/mhpq_pkg.sv
package mhpq_pkg;

    localparam int unsigned DATA_W  = 32;
    localparam int unsigned TOTAL_W = 8;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    typedef struct packed {
        logic                     operation;
        logic signed [DATA_W-1:0] new_value;
    } t_in_item;

    typedef struct packed {
        logic [1:0]               status;
        logic signed [DATA_W-1:0] out_value;
        logic signed [DATA_W-1:0] min_value;
        logic                     heap_empty;
        logic [TOTAL_W-1:0]       entry_total;
    } t_out_item;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_UP,
        S_UP_CMP,
        S_POP_LD,
        S_DN_RD,
        S_DN_CMP,
        S_ROOT_RD,
        S_ROOT_LD,
        S_RESULT
    } t_state;

    typedef enum logic [3:0] {
        DP_NONE,
        DP_LOAD,
        DP_SET_FULL,
        DP_SET_EMPTY,
        DP_PUSH_INIT,
        DP_PLACE,
        DP_UP_READ,
        DP_UP_STEP,
        DP_POP_READ,
        DP_POP_LOAD,
        DP_DN_READ,
        DP_DN_STEP,
        DP_ROOT_READ,
        DP_ROOT_LOAD
    } t_dp_cmd;

    typedef struct packed {
        logic op_pop;
        logic full;
        logic empty;
        logic at_root;
        logic up_more;
        logic dn_more;
    } t_dp_stat;

endpackage

>>> rtl/core/mhpq_ctrl.sv
module mhpq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_out_free,
    input  mhpq_pkg::t_dp_stat i_stat,
    output mhpq_pkg::t_dp_cmd  o_cmd,
    output logic              o_in_stall,
    output logic              o_done
);
    import mhpq_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_CHECK;
            end
            S_CHECK: begin
                if (i_stat.op_pop) begin
                    n_state = i_stat.empty ? S_ROOT_RD : S_POP_LD;
                end else begin
                    n_state = i_stat.full ? S_ROOT_RD : S_UP;
                end
            end
            S_UP:      n_state = i_stat.at_root ? S_ROOT_RD : S_UP_CMP;
            S_UP_CMP:  n_state = i_stat.up_more ? S_UP : S_ROOT_RD;
            S_POP_LD:  n_state = S_DN_RD;
            S_DN_RD:   n_state = S_DN_CMP;
            S_DN_CMP:  n_state = i_stat.dn_more ? S_DN_RD : S_ROOT_RD;
            S_ROOT_RD: n_state = S_ROOT_LD;
            S_ROOT_LD: n_state = S_RESULT;
            S_RESULT: begin
                if (i_out_free) n_state = S_IDLE;
            end
            default:   n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = DP_NONE;
        o_in_stall = 1'b1;
        o_done     = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) o_cmd = DP_LOAD;
            end
            S_CHECK: begin
                if (i_stat.op_pop) begin
                    o_cmd = i_stat.empty ? DP_SET_EMPTY : DP_POP_READ;
                end else begin
                    o_cmd = i_stat.full ? DP_SET_FULL : DP_PUSH_INIT;
                end
            end
            S_UP:      o_cmd = i_stat.at_root ? DP_PLACE : DP_UP_READ;
            S_UP_CMP:  o_cmd = DP_UP_STEP;
            S_POP_LD:  o_cmd = DP_POP_LOAD;
            S_DN_RD:   o_cmd = DP_DN_READ;
            S_DN_CMP:  o_cmd = DP_DN_STEP;
            S_ROOT_RD: o_cmd = DP_ROOT_READ;
            S_ROOT_LD: o_cmd = DP_ROOT_LOAD;
            S_RESULT:  o_done = i_out_free;
            default:   o_cmd = DP_NONE;
        endcase
    end

    a_load_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd == DP_LOAD) |-> (r_state == S_IDLE && !o_in_stall))
        else $error("load outside idle");
    a_done_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> (r_state == S_IDLE))
        else $error("done did not return to idle");
    a_accept_to_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state == S_CHECK))
        else $error("accepted item not checked");

endmodule

>>> rtl/core/mhpq_dpath.sv
module mhpq_dpath #(
    parameter int unsigned CAPACITY = 128
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mhpq_pkg::t_dp_cmd   i_cmd,
    input  mhpq_pkg::t_in_item  i_item,
    output mhpq_pkg::t_dp_stat  o_stat,
    output mhpq_pkg::t_out_item o_result
);
    import mhpq_pkg::*;

    localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned CW = $clog2(CAPACITY + 1);
    localparam int unsigned LW = AW + 2;
    localparam int unsigned EW = (CW > TOTAL_W) ? CW : TOTAL_W;

    logic [DATA_W-1:0] r_mem [CAPACITY];
    logic [DATA_W-1:0] r_rd_a;
    logic [DATA_W-1:0] r_rd_b;

    logic [CW-1:0]     r_count;
    logic [AW-1:0]     r_pos;
    logic [DATA_W-1:0] r_val;
    logic              r_op;
    logic [1:0]        r_status;
    logic [DATA_W-1:0] r_popped;
    logic [DATA_W-1:0] r_min;

    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [DATA_W-1:0] wr_data;
    logic [AW-1:0]     rd_addr_a;
    logic [AW-1:0]     rd_addr_b;

    logic [AW-1:0]     parent;
    logic [LW-1:0]     left_w;
    logic [LW-1:0]     right_w;
    logic [LW-1:0]     count_w;
    logic              left_ok;
    logic              right_ok;
    logic              l_lt;
    logic              r_lt;
    logic [DATA_W-1:0] best_val;
    logic              up_lt;
    logic [CW-1:0]     last;
    logic [EW-1:0]     count_ext;

    assign parent   = AW'((r_pos - AW'(1)) >> 1);
    assign left_w   = LW'({r_pos, 1'b1});
    assign right_w  = left_w + LW'(1);
    assign count_w  = LW'(r_count);
    assign left_ok  = left_w < count_w;
    assign right_ok = right_w < count_w;
    assign l_lt     = left_ok && ($signed(r_rd_a) < $signed(r_val));
    assign best_val = l_lt ? r_rd_a : r_val;
    assign r_lt     = right_ok && ($signed(r_rd_b) < $signed(best_val));
    assign up_lt    = $signed(r_val) < $signed(r_rd_a);
    assign last     = r_count - CW'(1);

    assign o_stat.op_pop  = r_op;
    assign o_stat.full    = r_count == CW'(CAPACITY);
    assign o_stat.empty   = r_count == '0;
    assign o_stat.at_root = r_pos == '0;
    assign o_stat.up_more = up_lt;
    assign o_stat.dn_more = l_lt || r_lt;

    always_comb begin
        wr_en     = 1'b0;
        wr_addr   = r_pos;
        wr_data   = r_val;
        rd_addr_a = '0;
        rd_addr_b = '0;
        case (i_cmd)
            DP_PLACE: wr_en = 1'b1;
            DP_UP_READ: rd_addr_a = parent;
            DP_UP_STEP: begin
                wr_en   = 1'b1;
                wr_data = up_lt ? r_rd_a : r_val;
            end
            DP_POP_READ: rd_addr_b = AW'(last);
            DP_DN_READ: begin
                rd_addr_a = left_w[AW-1:0];
                rd_addr_b = right_w[AW-1:0];
            end
            DP_DN_STEP: begin
                wr_en   = 1'b1;
                wr_data = r_lt ? r_rd_b : (l_lt ? r_rd_a : r_val);
            end
            default: wr_en = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) r_mem[wr_addr] <= wr_data;
        r_rd_a <= r_mem[rd_addr_a];
        r_rd_b <= r_mem[rd_addr_b];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            case (i_cmd)
                DP_PUSH_INIT: r_count <= r_count + CW'(1);
                DP_POP_READ:  r_count <= last;
                default:      r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd)
            DP_LOAD: begin
                r_op     <= i_item.operation;
                r_val    <= i_item.new_value;
                r_status <= ST_OK;
                r_popped <= '0;
            end
            DP_SET_FULL:  r_status <= ST_FULL;
            DP_SET_EMPTY: r_status <= ST_EMPTY;
            DP_PUSH_INIT: r_pos <= AW'(r_count);
            DP_UP_STEP: begin
                if (up_lt) r_pos <= parent;
            end
            DP_POP_READ: r_pos <= '0;
            DP_POP_LOAD: begin
                r_popped <= r_rd_a;
                r_val    <= r_rd_b;
            end
            DP_DN_STEP: begin
                if (r_lt) begin
                    r_pos <= right_w[AW-1:0];
                end else if (l_lt) begin
                    r_pos <= left_w[AW-1:0];
                end
            end
            DP_ROOT_LOAD: r_min <= (r_count != '0) ? r_rd_a : '0;
            default: r_pos <= r_pos;
        endcase
    end

    assign count_ext            = EW'(r_count);
    assign o_result.status      = r_status;
    assign o_result.out_value   = r_popped;
    assign o_result.min_value   = r_min;
    assign o_result.heap_empty  = r_count == '0;
    assign o_result.entry_total = count_ext[TOTAL_W-1:0];

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count above capacity");
    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd == DP_PUSH_INIT) |=> (r_count == $past(r_count) + CW'(1)))
        else $error("push did not add an entry");
    a_pop_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd == DP_POP_READ) |=> (r_count == $past(r_count) - CW'(1)))
        else $error("pop did not remove an entry");

endmodule

>>> rtl/core/min_heap_priority_queue.sv
// Binary min-heap in one memory with a registered result slot.
// Push: the new value climbs from the last slot toward the root, level by level, and stops at the
//   root or below a parent that is not larger; each level is one read and one compare/write.
// Pop: the last entry sinks from the root the same way; a refused push or an empty pop skips the walk.
// One item at a time: the next item is not accepted until the previous result lands.
// Synchronous active-low reset empties the heap and the result slot; no clearing pass.
module min_heap_priority_queue #(
    parameter int unsigned CAPACITY = 128
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  mhpq_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output mhpq_pkg::t_out_item o_out_item
);
    import mhpq_pkg::*;

    t_dp_cmd   cmd;
    t_dp_stat  stat;
    t_out_item result;
    logic      done;
    logic      out_free;
    logic      r_out_valid;
    t_out_item r_out_item;

    assign out_free = !r_out_valid || !i_out_stall;

    mhpq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_out_free (out_free),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall),
        .o_done     (done)
    );

    mhpq_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_item   (i_in_item),
        .o_stat   (stat),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (done) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done) r_out_item <= result;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

>>> test/min_heap_priority_queue_tb.sv
`timescale 1ns / 1ps

module min_heap_priority_queue_tb;
    import mhpq_pkg::*;

    localparam int unsigned HEAP_DEPTH    = 128;
    localparam int unsigned CLK_PERIOD    = 10;
    localparam int unsigned ITEM_GOAL     = 1750;
    localparam int unsigned HOLD_CYCLES   = 400;
    localparam int unsigned DRAIN_LIMIT   = 5000;
    localparam int unsigned SETTLE_CYCLES = 40;
    localparam longint      RUN_LIMIT_NS  = 20_000_000;

    class heap_scoreboard #(int unsigned DEPTH = 128);
        logic signed [DATA_W-1:0] slots [DEPTH];
        int unsigned held;
        t_out_item   pending_outcomes [$];
        int unsigned mismatches;
        int unsigned checked;
        int unsigned pushes;
        int unsigned pops;
        int unsigned refused;
        int unsigned empty_pops;
        int unsigned peak;

        function new();
            held       = 0;
            mismatches = 0;
            checked    = 0;
            pushes     = 0;
            pops       = 0;
            refused    = 0;
            empty_pops = 0;
            peak       = 0;
        endfunction

        function void swap_slots(int unsigned a, int unsigned b);
            logic signed [DATA_W-1:0] tmp;
            tmp      = slots[a];
            slots[a] = slots[b];
            slots[b] = tmp;
        endfunction

        function void raise_from(int unsigned pos);
            int unsigned up;
            while (pos > 0) begin
                up = (pos - 1) / 2;
                if (!(slots[pos] < slots[up]))
                    break;
                swap_slots(pos, up);
                pos = up;
            end
        endfunction

        function void sink_from(int unsigned pos);
            int unsigned best;
            int unsigned kid;
            while (1) begin
                best = pos;
                kid  = 2 * pos + 1;
                if (kid < held && slots[kid] < slots[best])
                    best = kid;
                if (kid + 1 < held && slots[kid + 1] < slots[best])
                    best = kid + 1;
                if (best == pos)
                    break;
                swap_slots(pos, best);
                pos = best;
            end
        endfunction

        function void note_request(t_in_item item);
            t_out_item res;
            res        = '0;
            res.status = ST_OK;
            if (item.operation == OP_PUSH) begin
                if (held >= DEPTH) begin
                    res.status = ST_FULL;
                    refused++;
                end else begin
                    slots[held] = item.new_value;
                    held++;
                    raise_from(held - 1);
                    pushes++;
                end
            end else begin
                if (held == 0) begin
                    res.status = ST_EMPTY;
                    empty_pops++;
                end else begin
                    res.out_value = slots[0];
                    held--;
                    slots[0] = slots[held];
                    sink_from(0);
                    pops++;
                end
            end
            if (held > peak)
                peak = held;
            res.min_value   = (held > 0) ? slots[0] : '0;
            res.heap_empty  = (held == 0);
            res.entry_total = TOTAL_W'(held);
            pending_outcomes.push_back(res);
        endfunction

        task report_mismatch(string msg);
            mismatches++;
            $display("[%0t] mismatch: %s", $time, msg);
        endtask

        task check_response(t_out_item got);
            t_out_item want;
            checked++;
            if (pending_outcomes.size() == 0) begin
                report_mismatch($sformatf("result %0d with none pending: %h", checked, got));
                return;
            end
            want = pending_outcomes.pop_front();
            if (got.status !== want.status)
                report_mismatch($sformatf("result %0d status %0d, want %0d",
                                          checked, got.status, want.status));
            if (got.out_value !== want.out_value)
                report_mismatch($sformatf("result %0d out_value %0d, want %0d",
                                          checked, got.out_value, want.out_value));
            if (got.min_value !== want.min_value)
                report_mismatch($sformatf("result %0d min_value %0d, want %0d",
                                          checked, got.min_value, want.min_value));
            if (got.heap_empty !== want.heap_empty)
                report_mismatch($sformatf("result %0d heap_empty %0d, want %0d",
                                          checked, got.heap_empty, want.heap_empty));
            if (got.entry_total !== want.entry_total)
                report_mismatch($sformatf("result %0d entry_total %0d, want %0d",
                                          checked, got.entry_total, want.entry_total));
        endtask
    endclass

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_stall;
    t_in_item  i_in_item   = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_item o_out_item;

    heap_scoreboard #(HEAP_DEPTH) sb;

    int unsigned items_sent      = 0;
    int unsigned pressure_rounds = 0;
    bit          quiet_phase     = 1'b0;
    logic        hold_off        = 1'b0;
    int unsigned stall_left      = 0;
    int unsigned free_left       = 0;

    min_heap_priority_queue #(
        .CAPACITY(HEAP_DEPTH)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_item (o_out_item)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    function automatic int unsigned idle_span();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_value(bit narrow);
        if (narrow)
            return int'($urandom_range(0, 6)) - 3;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return $urandom;
            5, 6:          return int'($urandom_range(0, 6)) - 3;
            7: begin
                case ($urandom_range(0, 5))
                    0:       return 32'h8000_0000;
                    1:       return 32'h7FFF_FFFF;
                    2:       return 32'h0000_0000;
                    3:       return 32'hFFFF_FFFF;
                    4:       return 32'h8000_0001;
                    default: return 32'h7FFF_FFFE;
                endcase
            end
            default:       return int'($urandom_range(0, 2000)) - 1000;
        endcase
    endfunction

    task automatic offer_item(input logic op, input logic signed [DATA_W-1:0] val);
        t_in_item    item;
        int unsigned pause;
        item.operation = op;
        item.new_value = val;
        pause = quiet_phase ? 0 : idle_span();
        if (pause > 0) begin
            i_in_valid <= 1'b0;
            repeat (pause) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= item;
        @(posedge i_clk);
        while (o_in_stall !== 1'b0)
            @(posedge i_clk);
        sb.note_request(item);
        items_sent++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_stall === 1'b0)
            sb.check_response(o_out_item);
        if (stall_left > 0)
            stall_left--;
        else if (free_left > 0)
            free_left--;
        else if ($urandom_range(0, 9) == 0)
            free_left = $urandom_range(30, 120);
        else
            stall_left = idle_span();
        i_out_stall <= hold_off || (stall_left > 0);
    end

    // hold off the result side while the sender keeps offering items
    initial begin
        for (int k = 1; k <= 2; k++) begin
            wait (pressure_rounds >= k);
            @(posedge i_clk);
            hold_off <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge i_clk);
            hold_off <= 1'b0;
        end
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("Verification failed");
        $finish;
    end

    initial begin
        int unsigned n;
        int unsigned span;
        int unsigned push_pct;
        int unsigned mode;
        int unsigned drain_wait;

        sb = new();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        offer_item(OP_POP, $urandom);
        offer_item(OP_POP, $urandom);
        offer_item(OP_PUSH, 32'h7FFF_FFFF);
        offer_item(OP_PUSH, 32'h8000_0000);
        offer_item(OP_PUSH, 32'h0000_0000);
        offer_item(OP_PUSH, 32'hFFFF_FFFF);
        offer_item(OP_PUSH, 32'h0000_0001);
        offer_item(OP_PUSH, 32'h0000_0005);
        offer_item(OP_PUSH, 32'h0000_0005);
        offer_item(OP_PUSH, 32'h0000_0005);
        offer_item(OP_PUSH, 32'hFFFF_FFFF);
        repeat (4) offer_item(OP_POP, $urandom);
        offer_item(OP_PUSH, 32'h5555_5555);
        offer_item(OP_PUSH, 32'hAAAA_AAAA);
        repeat (8) offer_item(OP_POP, $urandom);

        // fill past capacity, then drain past empty
        pressure_rounds = 1;
        n = HEAP_DEPTH + $urandom_range(4, 12);
        repeat (n) offer_item(OP_PUSH, pick_value(1'b0));
        n = sb.held + $urandom_range(2, 6);
        repeat (n) offer_item(OP_POP, $urandom);

        while (items_sent < ITEM_GOAL) begin
            mode        = $urandom_range(0, 3);
            quiet_phase = ($urandom_range(0, 3) == 0);
            push_pct    = (mode == 0) ? 85 : (mode == 1) ? 15 : 50;
            span        = $urandom_range(40, 200);
            if (span > ITEM_GOAL - items_sent)
                span = ITEM_GOAL - items_sent;
            if (items_sent > ITEM_GOAL / 2 && pressure_rounds < 2)
                pressure_rounds = 2;
            repeat (span)
                offer_item(($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_POP,
                           pick_value(mode == 3));
        end
        quiet_phase = 1'b0;
        i_in_valid <= 1'b0;

        drain_wait = 0;
        while (sb.pending_outcomes.size() > 0 && drain_wait < DRAIN_LIMIT) begin
            @(posedge i_clk);
            drain_wait++;
        end
        if (sb.pending_outcomes.size() > 0)
            sb.report_mismatch($sformatf("%0d results never arrived",
                                         sb.pending_outcomes.size()));
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Covered %0d items: %0d pushes, %0d pops, %0d refused when full, %0d pops when empty",
                 items_sent, sb.pushes, sb.pops, sb.refused, sb.empty_pops);
        $display("Peak fill %0d of %0d entries, %0d results checked, %0d mismatches",
                 sb.peak, HEAP_DEPTH, sb.checked, sb.mismatches);
        if (sb.mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
